// File: sv/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared types and constants for the page translation core: field widths,
// the sequencer state type and the tlb lookup result.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    // fixed field widths
    localparam int unsigned PAGE_W  = 8;
    localparam int unsigned FRAME_W = 8;
    localparam int unsigned CNT_W   = 32;

    // number of distinct page numbers on the input
    localparam int unsigned PAGE_SPAN = 1 << PAGE_W;

    // item kinds
    localparam logic KIND_LOOKUP  = 1'b0;
    localparam logic KIND_INSTALL = 1'b1;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_RESOLVE
    } seq_state_t;

    // tlb associative lookup result
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } cam_result_t;

endpackage

// File: sv/tlb_page_table_translate_core.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translate_core
// Page to frame translation through a fifo-replaced tlb backed by a direct
// page table held in a synchronous memory, with hit and fault counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries kind, page and frame. A
//   lookup (kind 0) searches the tlb, then the page table on a tlb miss. An
//   install (kind 1) writes the page table entry and the tlb slot at the
//   fifo pointer.
//   Output channel (out_valid / out_stall) returns one result per transfer:
//   tlb_hit, fault, frame_out and the running hit and fault counts.
//   An accepted item has its tlb tag compare and page table read registered
//   at the accepting edge and is resolved in the following cycle, in the
//   resolve state; in_stall is high there, so no new item is taken until
//   the resolved result moves on to the output register.
//   The result sits in an output register, so the next item is taken while
//   a finished result still waits. When the receiver stalls with a result
//   pending, the next result is held in the resolve state and in_stall stays
//   high until the output register frees up.
//   Reset clears the tlb, the page table valid bits, the fifo pointer and
//   both counters at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tlb_page_table_translate_core #(
    parameter int PAGE_COUNT  = 256,
    parameter int TLB_ENTRIES = 16,
    parameter int FRAME_COUNT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [tlbpt_pkg::PAGE_W-1:0]  page,
    input  logic [tlbpt_pkg::FRAME_W-1:0] frame,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          tlb_hit,
    output logic                          fault,
    output logic [tlbpt_pkg::FRAME_W-1:0] frame_out,
    output logic [tlbpt_pkg::CNT_W-1:0]   hits_so_far,
    output logic [tlbpt_pkg::CNT_W-1:0]   faults_so_far
);
    import tlbpt_pkg::*;

    // only the first PAGE_SPAN entries can ever be addressed
    localparam int PT_DEPTH = (PAGE_COUNT < PAGE_SPAN) ? PAGE_COUNT : PAGE_SPAN;
    localparam int PT_AW    = $clog2(PT_DEPTH);

    // page index and frame reduction tables, built at elaboration
    logic [PT_AW-1:0]   pidx_lut  [PAGE_SPAN];
    logic [FRAME_W-1:0] frame_lut [PAGE_SPAN];

    for (genvar gi = 0; gi < PAGE_SPAN; gi++)
    begin : g_lut
        localparam int unsigned PIDX = gi % PAGE_COUNT;
        localparam int unsigned FRED = gi % FRAME_COUNT;
        assign pidx_lut[gi]  = PT_AW'(PIDX);
        assign frame_lut[gi] = FRAME_W'(FRED);
    end

    seq_state_t state_reg;
    seq_state_t state_next;

    logic in_xfer;
    logic out_free;
    logic resolve_done;

    logic [PT_AW-1:0]   pidx;
    logic [FRAME_W-1:0] frame_red;
    logic               install;

    // page table storage: frame memory plus valid flops
    logic [FRAME_W-1:0]  pt_mem [PT_DEPTH];
    logic [PT_DEPTH-1:0] pt_vld_reg;
    logic [FRAME_W-1:0]  rd_frame_reg;
    logic                rd_vld_reg;

    // item captured at the accepting edge
    logic        kind_reg;
    cam_result_t cam_res;
    cam_result_t cam_res_reg;

    // resolved result
    logic               res_hit;
    logic               res_fault;
    logic [FRAME_W-1:0] res_frame;

    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_next;
    logic [CNT_W-1:0] flt_cnt_reg;
    logic [CNT_W-1:0] flt_cnt_next;

    logic               out_valid_reg;
    logic               out_hit_reg;
    logic               out_fault_reg;
    logic [FRAME_W-1:0] out_frame_reg;

    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pidx      = pidx_lut[page];
    assign frame_red = frame_lut[frame];
    assign install   = in_xfer && (kind == KIND_INSTALL);

    // tlb
    tlbpt_cam #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_cam (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (install),
        .wr_page  (page),
        .wr_frame (frame_red),
        .lk_page  (page),
        .result   (cam_res)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall     = 1'b1;
        resolve_done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_RESOLVE:
            begin
                resolve_done = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // page table memory: write on install, registered read on every transfer
    always_ff @(posedge clk)
    begin
        if (install)
        begin
            pt_mem[pidx] <= frame_red;
        end
        if (in_xfer)
        begin
            rd_frame_reg <= pt_mem[pidx];
        end
    end

    // page table valid bits and read-side valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_vld_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            rd_vld_reg <= pt_vld_reg[pidx];
            if (kind == KIND_INSTALL)
            begin
                pt_vld_reg[pidx] <= 1'b1;
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg    <= kind;
            cam_res_reg <= cam_res;
        end
    end

    // resolve hit, fault and frame
    always_comb
    begin
        res_hit   = 1'b0;
        res_fault = 1'b0;
        res_frame = '0;
        if (kind_reg == KIND_LOOKUP)
        begin
            if (cam_res_reg.hit)
            begin
                res_hit   = 1'b1;
                res_frame = cam_res_reg.frame;
            end
            else if (rd_vld_reg)
            begin
                res_frame = rd_frame_reg;
            end
            else
            begin
                res_fault = 1'b1;
            end
        end
    end

    assign hit_cnt_next = hit_cnt_reg + CNT_W'(res_hit);
    assign flt_cnt_next = flt_cnt_reg + CNT_W'(res_fault);

    // counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            flt_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (resolve_done)
            begin
                hit_cnt_reg   <= hit_cnt_next;
                flt_cnt_reg   <= flt_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (resolve_done)
        begin
            out_hit_reg   <= res_hit;
            out_fault_reg <= res_fault;
            out_frame_reg <= res_frame;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tlb_hit       = out_hit_reg;
    assign fault         = out_fault_reg;
    assign frame_out     = out_frame_reg;
    assign hits_so_far   = hit_cnt_reg;
    assign faults_so_far = flt_cnt_reg;

    // an accepted item always moves the sequencer out of idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_RESOLVE))
        else $error("accepted item did not enter resolve");

    // a resolved item is always presented on the next cycle
    a_resolve_out: assert property (@(posedge clk) disable iff (!rst_n)
        resolve_done |=> out_valid_reg)
        else $error("resolved item not presented");

    // a fault never reports a hit or a frame
    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fault_reg) |-> (!out_hit_reg && (out_frame_reg == '0)))
        else $error("fault result carries hit or frame");

    // the hit count moves only on a resolved hit
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        !(resolve_done && res_hit) |=> $stable(hit_cnt_reg))
        else $error("hit count changed without a hit");

endmodule

// File: sv/tlbpt_cam.sv
// ----------------------------------------------------------------------------
// tlbpt_cam
// Fully associative tlb with fifo replacement. Compares a page against all
// valid entries in parallel, lowest matching slot wins. A write fills the
// slot at the fifo pointer and advances the pointer.
// ----------------------------------------------------------------------------
module tlbpt_cam #(
    parameter int TLB_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [tlbpt_pkg::PAGE_W-1:0]  wr_page,
    input  logic [tlbpt_pkg::FRAME_W-1:0] wr_frame,
    input  logic [tlbpt_pkg::PAGE_W-1:0]  lk_page,
    output tlbpt_pkg::cam_result_t        result
);
    import tlbpt_pkg::*;

    localparam int SLOT_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TLB_ENTRIES - 1);

    logic [PAGE_W-1:0]  tag_reg   [TLB_ENTRIES];
    logic [FRAME_W-1:0] frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] vld_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;

    // fifo pointer advance with wrap
    always_comb
    begin
        if (slot_reg == LAST_SLOT)
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + SLOT_W'(1);
        end
    end

    // entry fill and pointer update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            vld_reg  <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                tag_reg[i]   <= '0;
                frame_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            tag_reg[slot_reg]   <= wr_page;
            frame_reg[slot_reg] <= wr_frame;
            vld_reg[slot_reg]   <= 1'b1;
            slot_reg            <= slot_next;
        end
    end

    // parallel compare, lowest matching slot takes priority
    always_comb
    begin
        result = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (vld_reg[i] && (tag_reg[i] == lk_page))
            begin
                result.hit   = 1'b1;
                result.frame = frame_reg[i];
            end
        end
    end

endmodule

// File: verif/tlb_page_table_translate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translate_checker
// Watches both channels of the translation core. Every input transfer is run
// through a local copy of the tlb, the page table and the hit and fault
// counters. The predicted translation is queued and compared field by field
// with the next output transfer.
// ----------------------------------------------------------------------------
module tlb_page_table_translate_checker #(
    parameter int PAGE_COUNT  = 256,
    parameter int TLB_ENTRIES = 16,
    parameter int FRAME_COUNT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          kind,
    input  logic [tlbpt_pkg::PAGE_W-1:0]  page,
    input  logic [tlbpt_pkg::FRAME_W-1:0] frame,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          tlb_hit,
    input  logic                          fault,
    input  logic [tlbpt_pkg::FRAME_W-1:0] frame_out,
    input  logic [tlbpt_pkg::CNT_W-1:0]   hits_so_far,
    input  logic [tlbpt_pkg::CNT_W-1:0]   faults_so_far,
    output int                            error_count,
    output int                            pending_count
);
    import tlbpt_pkg::*;

    typedef struct packed {
        logic               hit;
        logic               fault;
        logic [FRAME_W-1:0] frame;
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   faults;
    } xlat_result_t;

    // local copy of the page table and the tlb
    logic               pt_valid     [PAGE_COUNT];
    logic [FRAME_W-1:0] pt_frame     [PAGE_COUNT];
    logic [PAGE_W-1:0]  tag_mirror   [TLB_ENTRIES];
    logic [FRAME_W-1:0] frame_mirror [TLB_ENTRIES];
    logic               tag_valid    [TLB_ENTRIES];
    int unsigned        fill_ptr;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   fault_total;

    xlat_result_t xlat_expected_q[$];
    xlat_result_t want;
    int           errors = 0;

    assign error_count = errors;

    task automatic report_error(input string msg);
        $display("%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                               input logic [CNT_W-1:0] exp_val);
        if (got !== exp_val)
            report_error($sformatf("%s mismatch: got %0h, expected %0h",
                                   name, got, exp_val));
    endtask

    // translate one item and update the local state
    function automatic xlat_result_t translate_page(input logic k,
                                                    input logic [PAGE_W-1:0] p,
                                                    input logic [FRAME_W-1:0] f);
        xlat_result_t res;
        int unsigned  pidx;
        int unsigned  fnum;
        logic         found;
        res   = '0;
        pidx  = p % PAGE_COUNT;
        found = 1'b0;
        if (k == KIND_INSTALL)
        begin
            fnum = (f % FRAME_COUNT) & 8'hFF;
            pt_valid[pidx]         = 1'b1;
            pt_frame[pidx]         = fnum[FRAME_W-1:0];
            tag_mirror[fill_ptr]   = p;
            frame_mirror[fill_ptr] = fnum[FRAME_W-1:0];
            tag_valid[fill_ptr]    = 1'b1;
            fill_ptr = (fill_ptr + 1) % TLB_ENTRIES;
        end
        else
        begin
            // lowest indexed valid match wins
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                if (!found && tag_valid[i] && tag_mirror[i] == p)
                begin
                    found     = 1'b1;
                    res.frame = frame_mirror[i];
                end
            end
            if (found)
            begin
                res.hit   = 1'b1;
                hit_total = hit_total + 1'b1;
            end
            else if (pt_valid[pidx])
            begin
                res.frame = pt_frame[pidx];
            end
            else
            begin
                res.fault   = 1'b1;
                fault_total = fault_total + 1'b1;
            end
        end
        res.hits   = hit_total;
        res.faults = fault_total;
        return res;
    endfunction

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAGE_COUNT; i++)
            begin
                pt_valid[i] = 1'b0;
                pt_frame[i] = '0;
            end
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                tag_mirror[i]   = '0;
                frame_mirror[i] = '0;
                tag_valid[i]    = 1'b0;
            end
            fill_ptr    = 0;
            hit_total   = '0;
            fault_total = '0;
            xlat_expected_q.delete();
            pending_count <= 0;
        end
        else
        begin
            // result transfer
            if (out_valid && !out_stall)
            begin
                if (xlat_expected_q.size() == 0)
                begin
                    report_error("result transfer with no expected result");
                end
                else
                begin
                    want = xlat_expected_q.pop_front();
                    check_field("tlb_hit", CNT_W'(tlb_hit), CNT_W'(want.hit));
                    check_field("fault", CNT_W'(fault), CNT_W'(want.fault));
                    check_field("frame_out", CNT_W'(frame_out), CNT_W'(want.frame));
                    check_field("hits_so_far", hits_so_far, want.hits);
                    check_field("faults_so_far", faults_so_far, want.faults);
                end
            end
            // input transfer
            if (in_valid && !in_stall)
                xlat_expected_q.push_back(translate_page(kind, page, frame));
            pending_count <= xlat_expected_q.size();
        end
    end

endmodule

// File: verif/tlb_page_table_translate_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translate_core_test
// Stimulus for the translation core: a directed run through empty lookups,
// extreme pages and frames, duplicate installs and a tlb eviction, then
// random lookups and installs over a small hot page set mixed with the full
// page range. Both sides idle at random, the receiver holds off once for a
// long stretch and the sender drains the core once mid-run. The checker
// beside the core does all prediction and comparison.
// ----------------------------------------------------------------------------
module tlb_page_table_translate_core_test;
    import tlbpt_pkg::*;

    localparam int          N_RANDOM    = 1875;
    localparam int          HOLD_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               kind;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic               out_valid;
    logic               out_stall;
    logic               tlb_hit;
    logic               fault;
    logic [FRAME_W-1:0] frame_out;
    logic [CNT_W-1:0]   hits_so_far;
    logic [CNT_W-1:0]   faults_so_far;

    int          error_count;
    int          pending_count;
    bit          no_idle  = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned cycle_count = 0;

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    tlb_page_table_translate_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .page          (page),
        .frame         (frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tlb_hit       (tlb_hit),
        .fault         (fault),
        .frame_out     (frame_out),
        .hits_so_far   (hits_so_far),
        .faults_so_far (faults_so_far)
    );

    tlb_page_table_translate_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .page          (page),
        .frame         (frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tlb_hit       (tlb_hit),
        .fault         (fault),
        .frame_out     (frame_out),
        .hits_so_far   (hits_so_far),
        .faults_so_far (faults_so_far),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= !no_idle && ($urandom_range(0, 99) < 10);
            end
        end
    end

    // one input transfer, with an occasional idle gap ahead of it
    task automatic send_item(input logic k, input logic [PAGE_W-1:0] p,
                             input logic [FRAME_W-1:0] f);
        int gap;
        if (!no_idle && $urandom_range(0, 99) < 10)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        page     <= p;
        frame    <= f;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // stop offering and wait for every outstanding translation
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int                pick;
        logic [PAGE_W-1:0] pg;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        kind     <= KIND_LOOKUP;
        page     <= '0;
        frame    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lookups on an empty table fault
        send_item(KIND_LOOKUP, 8'h00, 8'h00);
        send_item(KIND_LOOKUP, 8'hFF, 8'hFF);
        // extreme pages and frames
        send_item(KIND_INSTALL, 8'h00, 8'hFF);
        send_item(KIND_INSTALL, 8'hFF, 8'h00);
        send_item(KIND_LOOKUP, 8'h00, 8'h00);
        send_item(KIND_LOOKUP, 8'hFF, 8'h00);
        // alternating bit patterns
        send_item(KIND_INSTALL, 8'h5A, 8'hA5);
        send_item(KIND_INSTALL, 8'hA5, 8'h5A);
        send_item(KIND_LOOKUP, 8'h5A, 8'hFF);
        send_item(KIND_LOOKUP, 8'hA5, 8'h00);
        // same page in two slots, the lower one answers
        send_item(KIND_INSTALL, 8'h05, 8'h0A);
        send_item(KIND_INSTALL, 8'h05, 8'h14);
        send_item(KIND_LOOKUP, 8'h05, 8'h00);
        // wrap the fill pointer so page 0 leaves the tlb
        for (int i = 0; i < 11; i++)
            send_item(KIND_INSTALL, 8'(8'h10 + i), 8'(8'hEF - i));
        // tlb miss served by the page table
        send_item(KIND_LOOKUP, 8'h00, 8'h00);

        // random lookups and installs, mostly over a hot page set
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 500)
                no_idle = 1'b1;
            if (n == 800)
                no_idle = 1'b0;
            if (n == 1000)
                hold_req = 1'b1;
            if (n == 1300)
                wait_for_drain();
            pick = $urandom_range(0, 99);
            if (pick < 70)
                pg = 8'($urandom_range(0, 23) * 11);
            else
                pg = 8'($urandom_range(0, 255));
            send_item(($urandom_range(0, 99) < 30) ? KIND_INSTALL : KIND_LOOKUP,
                      pg, 8'($urandom_range(0, 255)));
        end

        wait_for_drain();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
